>>> hw/rtl/morse_press_decoder_assert.svh
// Assertion macros shared by the morse press decoder RTL.
`ifndef MORSE_PRESS_DECODER_ASSERT_SVH
`define MORSE_PRESS_DECODER_ASSERT_SVH

// Check that a condition implies an expression in the same cycle.
`define MPD_ASSERT_IMP(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("morse_press_decoder: same-cycle check failed");

// Check that a condition implies an expression in the next cycle.
`define MPD_ASSERT_NXT(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("morse_press_decoder: next-cycle check failed");

`endif

>>> hw/rtl/mpd_pkg.sv
// Package with constants, types and the letter lookup of the morse press decoder.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

   localparam int unsigned DURATION_WIDTH = 16;
   localparam int unsigned LIMIT_WIDTH    = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned MAX_SYMBOLS    = 4;
   localparam int unsigned BITS_WIDTH     = 4;
   localparam int unsigned LENGTH_WIDTH   = 3;
   localparam int unsigned CODE_WIDTH     = 7;

   localparam logic [LIMIT_WIDTH-1:0]  SHORT_LIMIT_RESET = 16'd400;
   localparam logic [LIMIT_WIDTH-1:0]  LONG_LIMIT_RESET  = 16'd1000;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX        = 3'(MAX_SYMBOLS);
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_OVERFLOW   = 3'(MAX_SYMBOLS + 1);
   localparam logic [CODE_WIDTH-1:0]   ASCII_A           = 7'd65;
   localparam logic [CODE_WIDTH-1:0]   ASCII_L           = 7'd76;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHORT_LIMIT = 1'b0,
      CSR_LONG_LIMIT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EVENT_DOT       = 2'd0,
      EVENT_DASH      = 2'd1,
      EVENT_FOUND     = 2'd2,
      EVENT_NOT_FOUND = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic                  found;
      logic [CODE_WIDTH-1:0] code;
   } lookup_type;

   // Match a pattern (length, bits with first symbol in bit 0, dash = 1) to A..L.
   function automatic lookup_type letter_lookup(
      input logic [LENGTH_WIDTH-1:0] length,
      input logic [BITS_WIDTH-1:0]   bits
   );
      lookup_type res;
      logic [3:0] idx;
      res.found = 1'b1;
      idx       = 4'd0;
      unique case ({length, bits})
         {3'd2, 4'h2}: idx = 4'd0;   // A .-
         {3'd4, 4'h1}: idx = 4'd1;   // B -...
         {3'd4, 4'h5}: idx = 4'd2;   // C -.-.
         {3'd3, 4'h1}: idx = 4'd3;   // D -..
         {3'd1, 4'h0}: idx = 4'd4;   // E .
         {3'd4, 4'h4}: idx = 4'd5;   // F ..-.
         {3'd3, 4'h3}: idx = 4'd6;   // G --.
         {3'd4, 4'h0}: idx = 4'd7;   // H ....
         {3'd2, 4'h0}: idx = 4'd8;   // I ..
         {3'd4, 4'hE}: idx = 4'd9;   // J .---
         {3'd3, 4'h5}: idx = 4'd10;  // K -.-
         {3'd4, 4'h2}: idx = 4'd11;  // L .-..
         default:      res.found = 1'b0;
      endcase
      res.code = res.found ? (ASCII_A + {3'b000, idx}) : '0;
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/morse_press_decoder.sv
// Morse press decoder: classifies press durations and decodes letters A to L.
// A request moves from the input register to the response register when that frees.
// Throughput: one request per cycle while rsp_ready is high; the input register and
// the response register each hold one request, and pattern update plus table match are combinational.
// Reset clears the pattern, both pipeline valid flags, and loads the limits with
// 400 ms and 1000 ms. Configuration writes complete in the cycle they are offered.
`timescale 1ns / 1ps
`default_nettype none

module morse_press_decoder
   import mpd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Configuration port
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [LIMIT_WIDTH-1:0]     csr_data,
   // Request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [DURATION_WIDTH-1:0]  req_press_duration,
   // Response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_event_kind,
   output logic [CODE_WIDTH-1:0]           rsp_letter_code
);

   logic [LIMIT_WIDTH-1:0]    short_limit_ff, short_limit_in;
   logic [LIMIT_WIDTH-1:0]    long_limit_ff, long_limit_in;
   logic                      in_valid_ff, in_valid_in;
   logic [DURATION_WIDTH-1:0] in_duration_ff, in_duration_in;
   logic [BITS_WIDTH-1:0]     symbol_bits_ff, symbol_bits_in;
   logic [LENGTH_WIDTH-1:0]   symbol_length_ff, symbol_length_in;
   logic                      out_valid_ff, out_valid_in;
   event_kind_type            out_kind_ff, out_kind_in;
   logic [CODE_WIDTH-1:0]     out_code_ff, out_code_in;
   logic                      advance;
   logic                      is_dot;
   logic                      is_dash;
   logic                      is_symbol;
   lookup_type                match;

   assign csr_ready = 1'b1;

   // Move the held request to the response register when that register frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Write the limits.
   always_comb begin
      short_limit_in = short_limit_ff;
      long_limit_in  = long_limit_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHORT_LIMIT: short_limit_in = csr_data;
            CSR_LONG_LIMIT:  long_limit_in  = csr_data;
            default:         ;
         endcase
      end
   end

   // Load the input register.
   always_comb begin
      in_valid_in    = in_valid_ff;
      in_duration_in = in_duration_ff;
      if (req_ready) begin
         in_valid_in    = req_valid;
         in_duration_in = req_press_duration;
      end
   end

   // Classify the press and update the pattern.
   assign is_dot    = in_duration_ff < short_limit_ff;
   assign is_dash   = !is_dot && (in_duration_ff < long_limit_ff);
   assign is_symbol = is_dot || is_dash;
   assign match     = letter_lookup(symbol_length_ff, symbol_bits_ff);

   always_comb begin
      symbol_bits_in   = symbol_bits_ff;
      symbol_length_in = symbol_length_ff;
      out_kind_in      = out_kind_ff;
      out_code_in      = out_code_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      if (advance) begin
         out_valid_in = 1'b1;
         out_code_in  = '0;
         if (is_symbol) begin
            out_kind_in = is_dot ? EVENT_DOT : EVENT_DASH;
            if (symbol_length_ff < LENGTH_MAX) begin
               symbol_bits_in   = symbol_bits_ff |
                  (BITS_WIDTH'(is_dash) << symbol_length_ff[1:0]);
               symbol_length_in = symbol_length_ff + 3'd1;
            end else begin
               symbol_length_in = LENGTH_OVERFLOW;
            end
         end else begin
            // End the letter; the overflow length never matches the table.
            out_kind_in      = match.found ? EVENT_FOUND : EVENT_NOT_FOUND;
            out_code_in      = match.code;
            symbol_bits_in   = '0;
            symbol_length_in = '0;
         end
      end
   end

   // Hold control state under reset; payload registers load freely.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff   <= SHORT_LIMIT_RESET;
         long_limit_ff    <= LONG_LIMIT_RESET;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         symbol_bits_ff   <= '0;
         symbol_length_ff <= '0;
      end else begin
         short_limit_ff   <= short_limit_in;
         long_limit_ff    <= long_limit_in;
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         symbol_bits_ff   <= symbol_bits_in;
         symbol_length_ff <= symbol_length_in;
      end
   end

   always_ff @(posedge clock) begin
      in_duration_ff <= in_duration_in;
      out_kind_ff    <= out_kind_in;
      out_code_ff    <= out_code_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_letter_code = out_code_ff;

`include "morse_press_decoder_assert.svh"

   `MPD_ASSERT_IMP(a_length_range, 1'b1, symbol_length_ff <= LENGTH_OVERFLOW)
   `MPD_ASSERT_IMP(a_found_code, out_valid_ff && out_kind_ff == EVENT_FOUND,
      out_code_ff >= ASCII_A && out_code_ff <= ASCII_L)
   `MPD_ASSERT_IMP(a_other_code, out_valid_ff && out_kind_ff != EVENT_FOUND,
      out_code_ff == '0)
   `MPD_ASSERT_NXT(a_end_clears, advance && !is_symbol,
      symbol_length_ff == '0 && symbol_bits_ff == '0)
   `MPD_ASSERT_NXT(a_hold_input, in_valid_ff && !advance,
      in_valid_ff && $stable(in_duration_ff))

endmodule

`default_nettype wire
